@@ hw/rtl/cil_pkg.sv @@
// Shared constants and types for the cached interval lookup block.
package cil_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int COUNT_W     = ADDR_W + 1;
    localparam int SIDX_W      = ADDR_W + 2;
    localparam int FRAME_W     = 31;
    localparam int GAP_W       = 32;
    localparam int ENTRY_W     = 2 * FRAME_W;
    localparam int IN_DATA_W   = ((ADDR_W + 3 * FRAME_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((ADDR_W + 7) / 8) * 8;

    localparam logic [GAP_W-1:0] GAP_TOP   = 32'h7FFF_FFFF;
    localparam logic [GAP_W-1:0] GAP_RESET = 32'hFFFF_FFFF;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic [FRAME_W-1:0] end_frame;
        logic [FRAME_W-1:0] start_frame;
    } entry_t;

endpackage

@@ hw/rtl/cil_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cil_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/cached_interval_lookup_top.sv @@
// Top level of the cached interval lookup: entry table, caches and search sequencer.
//
// Loads write one table entry and clear the caches. A query is answered from the gap
// cache on a hit, else by a cursor check and a binary search over up to n = 1024
// entries, and the slave side is not ready meanwhile. The entry table has a single
// read port: every binary search probe does the registered read and then the frame
// compare in the shared compare unit.
// A finished result waits in the output register while the next item is taken.
module cached_interval_lookup_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cil_pkg::COUNT_W-1:0]       cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // entry_index[9:0], entry_start[40:10], entry_end[71:41], frame[102:72], zero pad
    input  logic [cil_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // func
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // interval_index[9:0], zero pad
    output logic [cil_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // has_interval
    output logic                              m_axis_tuser
);

    localparam int FW  = cil_pkg::FRAME_W;
    localparam int AW  = cil_pkg::ADDR_W;
    localparam int CW  = cil_pkg::COUNT_W;
    localparam int SW  = cil_pkg::SIDX_W;
    localparam int GW  = cil_pkg::GAP_W;
    localparam int ODW = cil_pkg::OUT_DATA_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_HIT_CMP = 4'd1;
    localparam logic [3:0] S_CUR_B   = 4'd2;
    localparam logic [3:0] S_CUR_C   = 4'd3;
    localparam logic [3:0] S_SINIT   = 4'd4;
    localparam logic [3:0] S_PROBE   = 4'd5;
    localparam logic [3:0] S_STEP    = 4'd6;
    localparam logic [3:0] S_TAIL    = 4'd7;
    localparam logic [3:0] S_TAIL_LT = 4'd8;
    localparam logic [3:0] S_TAIL_GT = 4'd9;
    localparam logic [3:0] S_OUT     = 4'd10;

    logic [3:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  hit_valid_reg, hit_valid_next;
    logic [AW-1:0]         cursor_reg, cursor_next;
    logic [GW-1:0]         gap_low_reg, gap_low_next;
    logic [GW-1:0]         gap_high_reg, gap_high_next;
    logic signed [SW-1:0]  lo_reg, lo_next;
    logic signed [SW-1:0]  hi_reg, hi_next;
    logic [AW-1:0]         mid_reg, mid_next;
    logic                  lt_reg, lt_next;
    logic                  out_valid_reg, out_valid_next;

    logic [FW-1:0]         frame_reg, frame_next;
    logic [FW-1:0]         tmp_start_reg, tmp_start_next;
    logic [FW-1:0]         tmp_end_reg, tmp_end_next;
    logic                  res_hit_reg, res_hit_next;
    logic [AW-1:0]         res_idx_reg, res_idx_next;
    logic                  out_hit_reg, out_hit_next;
    logic [AW-1:0]         out_idx_reg, out_idx_next;

    logic [CW-1:0]         live_n;
    logic                  in_accept;
    logic [FW-1:0]         in_frame;
    logic [AW-1:0]         in_index;
    cil_pkg::entry_t       wr_entry;
    cil_pkg::entry_t       rd_entry;
    logic [AW-1:0]         raddr;
    logic [SW-1:0]         mid_sum;
    logic [AW-1:0]         probe_mid;
    logic                  cur_has_next;
    logic                  cmp_lt_start;
    logic                  cmp_gt_end;
    logic signed [SW-1:0]  step_lo;
    logic signed [SW-1:0]  step_hi;

    assign live_n = (count_reg > CW'(cil_pkg::MAX_ENTRIES)) ? CW'(cil_pkg::MAX_ENTRIES)
                                                            : count_reg;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_index      = s_axis_tdata[AW-1:0];
    assign in_frame      = s_axis_tdata[AW+3*FW-1:AW+2*FW];

    assign wr_entry.start_frame = s_axis_tdata[AW+FW-1:AW];
    assign wr_entry.end_frame   = s_axis_tdata[AW+2*FW-1:AW+FW];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tdata  = ODW'(out_idx_reg);

    assign mid_sum      = SW'(lo_reg) + SW'(hi_reg) + SW'(1);
    assign probe_mid    = mid_sum[AW:1];
    assign cur_has_next = ({1'b0, cursor_reg} + CW'(1)) < live_n;
    assign cmp_lt_start = frame_reg < rd_entry.start_frame;
    assign cmp_gt_end   = frame_reg > rd_entry.end_frame;
    assign step_lo      = $signed({2'b00, mid_reg}) + SW'(1);
    assign step_hi      = $signed({2'b00, mid_reg}) - SW'(1);

    always_comb
    begin
        case (state_reg)
            S_PROBE:   raddr = probe_mid;
            S_CUR_B:   raddr = cursor_reg + AW'(1);
            S_TAIL:    raddr = lt_reg ? (mid_reg - AW'(1)) : (mid_reg + AW'(1));
            default:   raddr = cursor_reg;
        endcase
    end

    cil_ram #(
        .WIDTH (cil_pkg::ENTRY_W),
        .DEPTH (cil_pkg::MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (in_accept && (s_axis_tuser == cil_pkg::FUNC_LOAD)),
        .waddr (in_index),
        .wdata (wr_entry),
        .raddr (raddr),
        .rdata (rd_entry)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        hit_valid_next = hit_valid_reg;
        cursor_next    = cursor_reg;
        gap_low_next   = gap_low_reg;
        gap_high_next  = gap_high_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        lt_next        = lt_reg;
        out_valid_next = out_valid_reg;
        frame_next     = frame_reg;
        tmp_start_next = tmp_start_reg;
        tmp_end_next   = tmp_end_reg;
        res_hit_next   = res_hit_reg;
        res_idx_next   = res_idx_reg;
        out_hit_next   = out_hit_reg;
        out_idx_next   = out_idx_reg;

        if (cfg_valid && cfg_ready)
        begin
            count_next = cfg_data;
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    frame_next   = in_frame;
                    res_hit_next = 1'b0;
                    res_idx_next = '0;
                    if (s_axis_tuser == cil_pkg::FUNC_LOAD)
                    begin
                        hit_valid_next = 1'b0;
                        cursor_next    = '0;
                        gap_low_next   = cil_pkg::GAP_RESET;
                        gap_high_next  = cil_pkg::GAP_RESET;
                    end
                    else if (live_n == '0)
                    begin
                        state_next = S_OUT;
                    end
                    else if (hit_valid_reg)
                    begin
                        state_next = S_HIT_CMP;
                    end
                    else if (({1'b0, in_frame} > gap_low_reg) &&
                             ({1'b0, in_frame} < gap_high_reg))
                    begin
                        state_next = S_OUT;
                    end
                    else if (in_frame == '0)
                    begin
                        state_next = S_OUT;
                    end
                    else if (cur_has_next)
                    begin
                        state_next = S_CUR_B;
                    end
                    else
                    begin
                        state_next = S_SINIT;
                    end
                end
            end

            S_HIT_CMP:
            begin
                if (!cmp_lt_start && !cmp_gt_end)
                begin
                    res_hit_next = 1'b1;
                    res_idx_next = cursor_reg;
                    state_next   = S_OUT;
                end
                else
                begin
                    hit_valid_next = 1'b0;
                    if (frame_reg == '0)
                    begin
                        state_next = S_OUT;
                    end
                    else if (cur_has_next)
                    begin
                        state_next = S_CUR_B;
                    end
                    else
                    begin
                        state_next = S_SINIT;
                    end
                end
            end

            S_CUR_B:
            begin
                tmp_end_next = rd_entry.end_frame;
                state_next   = cmp_gt_end ? S_CUR_C : S_SINIT;
            end

            S_CUR_C:
            begin
                if (cmp_lt_start)
                begin
                    gap_low_next  = {1'b0, tmp_end_reg};
                    gap_high_next = {1'b0, rd_entry.start_frame};
                    state_next    = S_OUT;
                end
                else
                begin
                    state_next = S_SINIT;
                end
            end

            S_SINIT:
            begin
                lo_next    = '0;
                hi_next    = $signed({1'b0, live_n}) - SW'(1);
                state_next = S_PROBE;
            end

            S_PROBE:
            begin
                mid_next    = probe_mid;
                cursor_next = probe_mid;
                state_next  = S_STEP;
            end

            S_STEP:
            begin
                tmp_start_next = rd_entry.start_frame;
                tmp_end_next   = rd_entry.end_frame;
                lt_next        = cmp_lt_start;
                if (cmp_lt_start)
                begin
                    hi_next    = step_hi;
                    state_next = (step_hi >= lo_reg) ? S_PROBE : S_TAIL;
                end
                else if (cmp_gt_end)
                begin
                    lo_next    = step_lo;
                    state_next = (hi_reg >= step_lo) ? S_PROBE : S_TAIL;
                end
                else
                begin
                    hit_valid_next = 1'b1;
                    res_hit_next   = 1'b1;
                    res_idx_next   = mid_reg;
                    state_next     = S_OUT;
                end
            end

            S_TAIL:
            begin
                if (lt_reg)
                begin
                    if (mid_reg == '0)
                    begin
                        gap_low_next  = {1'b0, frame_reg} - GW'(1);
                        gap_high_next = {1'b0, tmp_start_reg};
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        cursor_next = mid_reg - AW'(1);
                        state_next  = S_TAIL_LT;
                    end
                end
                else if (({1'b0, mid_reg} + CW'(1)) >= live_n)
                begin
                    gap_low_next  = {1'b0, tmp_end_reg};
                    gap_high_next = cil_pkg::GAP_TOP;
                    state_next    = S_OUT;
                end
                else
                begin
                    state_next = S_TAIL_GT;
                end
            end

            S_TAIL_LT:
            begin
                if (cmp_gt_end && (frame_reg < tmp_start_reg))
                begin
                    gap_low_next  = {1'b0, rd_entry.end_frame};
                    gap_high_next = {1'b0, tmp_start_reg};
                end
                state_next = S_OUT;
            end

            S_TAIL_GT:
            begin
                if ((frame_reg > tmp_end_reg) && cmp_lt_start)
                begin
                    gap_low_next  = {1'b0, tmp_end_reg};
                    gap_high_next = {1'b0, rd_entry.start_frame};
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = res_hit_reg;
                    out_idx_next   = res_idx_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            hit_valid_reg <= 1'b0;
            cursor_reg    <= '0;
            gap_low_reg   <= cil_pkg::GAP_RESET;
            gap_high_reg  <= cil_pkg::GAP_RESET;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            lt_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            hit_valid_reg <= hit_valid_next;
            cursor_reg    <= cursor_next;
            gap_low_reg   <= gap_low_next;
            gap_high_reg  <= gap_high_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            lt_reg        <= lt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg     <= frame_next;
        tmp_start_reg <= tmp_start_next;
        tmp_end_reg   <= tmp_end_next;
        res_hit_reg   <= res_hit_next;
        res_idx_reg   <= res_idx_next;
        out_hit_reg   <= out_hit_next;
        out_idx_reg   <= out_idx_next;
    end

endmodule
